/* hdl/tile_scanline_renderer_macros.svh */
// Assertion macros of the tile scanline renderer, included by its top module.
`ifndef TILE_SCANLINE_RENDERER_MACROS_SVH
`define TILE_SCANLINE_RENDERER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TSR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define TSR_ASSERT_NEXT(lbl, cause, effect, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error(msg);
`else
`define TSR_ASSERT(lbl, prop, msg)
`define TSR_ASSERT_NEXT(lbl, cause, effect, msg)
`endif
`endif

/* hdl/tsr_pkg.sv */
// Types, constants and helper functions of the tile scanline renderer.
`default_nettype none
package tsr_pkg;
	localparam int VRAM_BYTES    = 8192;
	localparam int VRAM_AW       = 13;
	localparam int SPR_ENTRIES   = 40;
	localparam int SPR_BYTES     = 160;
	localparam int SPR_IW        = 6;
	localparam int MAX_SPR       = 10;
	localparam int LINE_PIXELS   = 160;
	localparam int GROUPS        = 20;
	localparam int GRP_W         = 5;

	localparam logic [12:0] MAP_BASE    = 13'h1800;
	localparam logic [12:0] MAP_SIZE    = 13'h0400;
	localparam logic [12:0] SIGNED_BASE = 13'h1000;
	localparam logic [7:0]  WIN_LINES   = 8'd144;

	localparam logic [1:0] FUNC_VRAM   = 2'd0;
	localparam logic [1:0] FUNC_SPRITE = 2'd1;
	localparam logic [1:0] FUNC_RENDER = 2'd2;

	localparam logic [2:0] REG_CTRL = 3'd0;
	localparam logic [2:0] REG_SCX  = 3'd1;
	localparam logic [2:0] REG_SCY  = 3'd2;
	localparam logic [2:0] REG_WTOP = 3'd3;
	localparam logic [2:0] REG_BGP  = 3'd4;
	localparam logic [2:0] REG_OBP0 = 3'd5;
	localparam logic [2:0] REG_OBP1 = 3'd6;

	typedef struct packed {
		logic [7:0] ctrl;
		logic [7:0] scx;
		logic [7:0] scy;
		logic [7:0] wtop;
		logic [7:0] bgp;
		logic [7:0] obp0;
		logic [7:0] obp1;
	} cfg_t;

	typedef struct packed {
		logic [7:0] flags;
		logic [7:0] tile;
		logic [7:0] x;
		logic [7:0] y;
	} spr_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEL,
		ST_BG_MAP,
		ST_BG_LO,
		ST_BG_HI,
		ST_BG_WT,
		ST_BG_PIX,
		ST_SP_START,
		ST_SP_HI,
		ST_SP_WT,
		ST_SP_RD,
		ST_SP_WR,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_WAIT
	} state_t;

	function automatic logic [1:0] tile_bit(input logic [7:0] lo, input logic [7:0] hi,
			input logic [2:0] col);
		logic [2:0] b;
		b = 3'd7 - col;
		return {hi[b], lo[b]};
	endfunction

	function automatic logic [1:0] pal_shade(input logic [7:0] pal, input logic [1:0] idx);
		return pal[{idx, 1'b0} +: 2];
	endfunction
endpackage
`default_nettype wire

/* hdl/tsr_ifs.sv */
// Valid/ready channel interfaces for render items and pixel groups.
`default_nettype none
interface tsr_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [12:0] mem_addr;
	logic [7:0]  mem_data;
	logic [7:0]  line;
	modport source (output valid, func, mem_addr, mem_data, line, input ready);
	modport sink (input valid, func, mem_addr, mem_data, line, output ready);
endinterface

interface tsr_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] shades;
	logic [4:0]  group;
	logic [7:0]  line_out;
	logic        last;
	modport source (output valid, shades, group, line_out, last, input ready);
	modport sink (input valid, shades, group, line_out, last, output ready);
endinterface
`default_nettype wire

/* hdl/tsr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hdl/tsr_regs.sv */
// APB configuration register file of the tile scanline renderer.
`default_nettype none
module tsr_regs (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire [4:0]         paddr,
	input  wire [31:0]        pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output tsr_pkg::cfg_t     cfg
);
	logic [2:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.ctrl <= 8'd0;
			cfg.scx  <= 8'd0;
			cfg.scy  <= 8'd0;
			cfg.wtop <= 8'd0;
			cfg.bgp  <= 8'd27;
			cfg.obp0 <= 8'd228;
			cfg.obp1 <= 8'd228;
		end else if (wr) begin
			unique case (idx)
				tsr_pkg::REG_CTRL: cfg.ctrl <= pwdata[7:0];
				tsr_pkg::REG_SCX:  cfg.scx  <= pwdata[7:0];
				tsr_pkg::REG_SCY:  cfg.scy  <= pwdata[7:0];
				tsr_pkg::REG_WTOP: cfg.wtop <= pwdata[7:0];
				tsr_pkg::REG_BGP:  cfg.bgp  <= pwdata[7:0];
				tsr_pkg::REG_OBP0: cfg.obp0 <= pwdata[7:0];
				tsr_pkg::REG_OBP1: cfg.obp1 <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			tsr_pkg::REG_CTRL: prdata = {24'd0, cfg.ctrl};
			tsr_pkg::REG_SCX:  prdata = {24'd0, cfg.scx};
			tsr_pkg::REG_SCY:  prdata = {24'd0, cfg.scy};
			tsr_pkg::REG_WTOP: prdata = {24'd0, cfg.wtop};
			tsr_pkg::REG_BGP:  prdata = {24'd0, cfg.bgp};
			tsr_pkg::REG_OBP0: prdata = {24'd0, cfg.obp0};
			tsr_pkg::REG_OBP1: prdata = {24'd0, cfg.obp1};
			default:           prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

/* hdl/tsr_sort.sv */
// Line sprite list kept in descending x order by stable insertion.
`default_nettype none
module tsr_sort (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               clear,
	input  wire               insert,
	input  tsr_pkg::spr_t     entry,
	input  wire [3:0]         rd_idx,
	output tsr_pkg::spr_t     rd_entry,
	output logic [3:0]        count
);
	tsr_pkg::spr_t list_q [tsr_pkg::MAX_SPR];
	logic [3:0]    count_q;
	logic          ge [tsr_pkg::MAX_SPR];
	logic          do_ins;

	assign count  = count_q;
	assign do_ins = insert && (count_q < 4'(tsr_pkg::MAX_SPR));

	always_comb begin
		for (int j = 0; j < tsr_pkg::MAX_SPR; j++) begin
			ge[j] = (4'(j) < count_q) && (list_q[j].x >= entry.x);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 4'd0;
		end else if (clear) begin
			count_q <= 4'd0;
		end else if (do_ins) begin
			count_q <= count_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_ins) begin
			for (int j = 0; j < tsr_pkg::MAX_SPR; j++) begin
				if (!ge[j]) begin
					if (j == 0) begin
						list_q[j] <= entry;
					end else if (ge[j-1]) begin
						list_q[j] <= entry;
					end else begin
						list_q[j] <= list_q[j-1];
					end
				end
			end
		end
	end

	assign rd_entry = (rd_idx < 4'(tsr_pkg::MAX_SPR)) ? list_q[rd_idx] : '0;
endmodule
`default_nettype wire

/* hdl/tile_scanline_renderer.sv */
// Tile scanline renderer: sequencer and shared fetch datapath.
//
// Items arrive on a valid/ready channel and are taken when both are high.
// A video memory or sprite memory write is done in the cycle it is taken. A render item
// produces twenty transfers on the result channel, one per group of eight
// pixels, the last one flagged.
// A render runs as a sequence over one video memory port and one line
// buffer port: sprite selection over the sprite memory, then the pixel
// pass with a fetch of map entry and tile row per background tile (none
// with background off), then the sprite pass, which draws each selected
// sprite and skips those at x zero, then the output of each group.
// The input is not ready from a render item until its last transfer.
// A stalled receiver holds the current group in the output register and
// the sequencer waits for it.
// After reset the video and sprite memories are cleared by a pass over
// every video memory address, during which no item is taken; configuration
// writes are accepted at any time the block is idle, over the APB port.
`default_nettype none
`include "tile_scanline_renderer_macros.svh"
module tile_scanline_renderer (
	input  wire                 clk,
	input  wire                 arst_n,
	tsr_item_if.sink            items,
	tsr_result_if.source        results,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire [4:0]           paddr,
	input  wire [31:0]          pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	tsr_pkg::cfg_t   cfg;
	tsr_pkg::state_t state_q, state_d;

	logic [12:0] clr_q;
	logic [7:0]  line_q, x_q, ym_q;
	logic        win_q, off_q;
	logic [12:0] map_q, rowaddr_q;
	logic [5:0]  sel_q;
	logic [7:0]  lo_q, hi_q;
	logic [31:0] pixacc_q;
	logic [3:0]  spi_q;
	logic        sword_q;
	tsr_pkg::spr_t spr_q;
	logic [4:0]  group_q;
	logic        ovalid_q, olast_q;
	logic [15:0] oshades_q;
	logic [4:0]  ogroup_q;
	logic [7:0]  oline_q;

	logic        accept, start;
	logic        tall;
	logic [4:0]  h;
	logic [7:0]  lw;
	logic        win;

	logic        vram_we;
	logic [12:0] vram_waddr, vram_raddr;
	logic [7:0]  vram_wdata, vram_rd;

	logic [3:0]  oam_we;
	logic [5:0]  oam_waddr, oam_raddr;
	logic [7:0]  oam_wdata;
	logic [7:0]  oam_rd [4];
	tsr_pkg::spr_t oam_entry;
	logic [9:0]  d_sel;
	logic        covered, insert;

	logic        line_we;
	logic [4:0]  line_waddr, line_raddr;
	logic [31:0] line_wdata, line_rd;

	logic [7:0]  xm;
	logic [12:0] map_addr, tbase, bg_rowaddr;
	logic [1:0]  bg_idx;
	logic [3:0]  bg_entry;

	tsr_pkg::spr_t cur;
	logic [3:0]  count;
	logic [7:0]  sp_tile, dsp;
	logic [3:0]  vrow;
	logic [12:0] sp_addr;
	logic        sp_go, skip;
	logic [8:0]  sxs;
	logic [5:0]  w;
	logic        w_ok;
	logic [31:0] sp_word;
	logic [7:0]  pal;
	logic        last_grp;

	tsr_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	assign items.ready = (state_q == tsr_pkg::ST_IDLE);
	assign accept      = items.valid && items.ready;
	assign start       = accept && (items.func == tsr_pkg::FUNC_RENDER);
	assign tall        = cfg.ctrl[2];
	assign h           = tall ? 5'd16 : 5'd8;
	assign lw          = items.line - cfg.wtop;
	assign win         = cfg.ctrl[5] && (items.line >= cfg.wtop) && (lw < tsr_pkg::WIN_LINES);
	assign last_grp    = (group_q == 5'(tsr_pkg::GROUPS - 1));

	// Video memory.
	tsr_ram #(.WIDTH(8), .DEPTH(tsr_pkg::VRAM_BYTES)) u_vram (
		.clk(clk), .we(vram_we), .waddr(vram_waddr), .wdata(vram_wdata),
		.raddr(vram_raddr), .rdata(vram_rd)
	);

	// Sprite memory, one byte lane per attribute byte.
	for (genvar b = 0; b < 4; b++) begin : g_oam
		tsr_ram #(.WIDTH(8), .DEPTH(tsr_pkg::SPR_ENTRIES)) u_oam (
			.clk(clk), .we(oam_we[b]), .waddr(oam_waddr), .wdata(oam_wdata),
			.raddr(oam_raddr), .rdata(oam_rd[b])
		);
	end

	// Line buffer, eight pixels of {background index, shade} per word.
	tsr_ram #(.WIDTH(32), .DEPTH(tsr_pkg::GROUPS)) u_line (
		.clk(clk), .we(line_we), .waddr(line_waddr), .wdata(line_wdata),
		.raddr(line_raddr), .rdata(line_rd)
	);

	tsr_sort u_sort (
		.clk(clk), .arst_n(arst_n), .clear(start), .insert(insert), .entry(oam_entry),
		.rd_idx(spi_q), .rd_entry(cur), .count(count)
	);

	// Sprite selection.
	assign oam_raddr = (sel_q >= 6'(tsr_pkg::SPR_ENTRIES)) ? 6'd0 : sel_q;
	assign oam_entry = {oam_rd[3], oam_rd[2], oam_rd[1], oam_rd[0]};
	assign d_sel     = {2'b00, line_q} + 10'd16 - {2'b00, oam_entry.y};
	assign covered   = !d_sel[9] && (d_sel[8:0] < {4'd0, h});
	assign insert    = (state_q == tsr_pkg::ST_SEL) && (sel_q != 6'd0) && covered;

	// Background fetch.
	assign xm         = win_q ? x_q : x_q + cfg.scx;
	assign map_addr   = map_q + {3'd0, ym_q[7:3], xm[7:3]};
	assign tbase      = cfg.ctrl[4] ? {1'b0, vram_rd, 4'd0}
	                                : tsr_pkg::SIGNED_BASE + {vram_rd[7], vram_rd, 4'd0};
	assign bg_rowaddr = tbase + {9'd0, ym_q[2:0], 1'b0};
	assign bg_idx     = off_q ? 2'd0 : tsr_pkg::tile_bit(lo_q, hi_q, xm[2:0]);
	assign bg_entry   = {bg_idx, tsr_pkg::pal_shade(cfg.bgp, bg_idx)};

	// Sprite drawing.
	assign sp_go   = cfg.ctrl[1] && (spi_q < count);
	assign skip    = (cur.x == 8'd0);
	assign sp_tile = tall ? {cur.tile[7:1], 1'b0} : cur.tile;
	assign dsp     = line_q + 8'd16 - cur.y;
	assign vrow    = cur.flags[6] ? ((tall ? 4'd15 : 4'd7) - dsp[3:0]) : dsp[3:0];
	assign sp_addr = {1'b0, sp_tile, 4'd0} + {8'd0, vrow, 1'b0};
	assign sxs     = {1'b0, spr_q.x} - 9'd8;
	assign w       = sxs[8:3] + {5'd0, sword_q};
	assign w_ok    = !w[5] && (w < 6'(tsr_pkg::GROUPS));
	assign pal     = spr_q.flags[4] ? cfg.obp1 : cfg.obp0;

	always_comb begin
		logic [7:0] p;
		logic [8:0] dd;
		logic [2:0] col;
		logic [1:0] c;
		logic [3:0] old;
		sp_word = line_rd;
		for (int k = 0; k < 8; k++) begin
			p   = {w[4:0], 3'(k)};
			dd  = {1'b0, p} + 9'd8 - {1'b0, spr_q.x};
			col = spr_q.flags[5] ? ~dd[2:0] : dd[2:0];
			c   = tsr_pkg::tile_bit(lo_q, hi_q, col);
			old = line_rd[4*k +: 4];
			if ((dd < 9'd8) && (c != 2'd0) && !(spr_q.flags[7] && (old[3:2] != 2'd0))) begin
				sp_word[4*k +: 4] = {old[3:2], tsr_pkg::pal_shade(pal, c)};
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsr_pkg::ST_CLEAR:    if (&clr_q) state_d = tsr_pkg::ST_IDLE;
			tsr_pkg::ST_IDLE:     if (start) state_d = tsr_pkg::ST_SEL;
			tsr_pkg::ST_SEL: begin
				if (sel_q == 6'(tsr_pkg::SPR_ENTRIES)) begin
					state_d = off_q ? tsr_pkg::ST_BG_PIX : tsr_pkg::ST_BG_MAP;
				end
			end
			tsr_pkg::ST_BG_MAP:   state_d = tsr_pkg::ST_BG_LO;
			tsr_pkg::ST_BG_LO:    state_d = tsr_pkg::ST_BG_HI;
			tsr_pkg::ST_BG_HI:    state_d = tsr_pkg::ST_BG_WT;
			tsr_pkg::ST_BG_WT:    state_d = tsr_pkg::ST_BG_PIX;
			tsr_pkg::ST_BG_PIX: begin
				if (x_q == 8'(tsr_pkg::LINE_PIXELS - 1)) begin
					state_d = tsr_pkg::ST_SP_START;
				end else if (!off_q && (xm[2:0] == 3'd7)) begin
					state_d = tsr_pkg::ST_BG_MAP;
				end
			end
			tsr_pkg::ST_SP_START: begin
				if (!sp_go) begin
					state_d = tsr_pkg::ST_OUT_RD;
				end else if (!skip) begin
					state_d = tsr_pkg::ST_SP_HI;
				end
			end
			tsr_pkg::ST_SP_HI:    state_d = tsr_pkg::ST_SP_WT;
			tsr_pkg::ST_SP_WT:    state_d = tsr_pkg::ST_SP_RD;
			tsr_pkg::ST_SP_RD: begin
				if (w_ok) begin
					state_d = tsr_pkg::ST_SP_WR;
				end else if (sword_q) begin
					state_d = tsr_pkg::ST_SP_START;
				end
			end
			tsr_pkg::ST_SP_WR:    state_d = sword_q ? tsr_pkg::ST_SP_START : tsr_pkg::ST_SP_RD;
			tsr_pkg::ST_OUT_RD:   state_d = tsr_pkg::ST_OUT_LD;
			tsr_pkg::ST_OUT_LD:   state_d = tsr_pkg::ST_OUT_WAIT;
			tsr_pkg::ST_OUT_WAIT: begin
				if (results.ready) begin
					state_d = last_grp ? tsr_pkg::ST_IDLE : tsr_pkg::ST_OUT_RD;
				end
			end
			default:              state_d = tsr_pkg::ST_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		vram_we    = 1'b0;
		vram_waddr = items.mem_addr;
		vram_wdata = items.mem_data;
		vram_raddr = 13'd0;
		oam_we     = 4'd0;
		oam_waddr  = items.mem_addr[7:2];
		oam_wdata  = items.mem_data;
		line_we    = 1'b0;
		line_waddr = x_q[7:3];
		line_wdata = {bg_entry, pixacc_q[27:0]};
		line_raddr = 5'd0;
		unique case (state_q)
			tsr_pkg::ST_CLEAR: begin
				vram_we    = 1'b1;
				vram_waddr = clr_q;
				vram_wdata = 8'd0;
				oam_waddr  = clr_q[5:0];
				oam_wdata  = 8'd0;
				oam_we     = (clr_q < 13'(tsr_pkg::SPR_ENTRIES)) ? 4'hF : 4'h0;
			end
			tsr_pkg::ST_IDLE: begin
				vram_we = accept && (items.func == tsr_pkg::FUNC_VRAM);
				if (accept && (items.func == tsr_pkg::FUNC_SPRITE)
						&& (items.mem_addr < 13'(tsr_pkg::SPR_BYTES))) begin
					oam_we[items.mem_addr[1:0]] = 1'b1;
				end
			end
			tsr_pkg::ST_BG_MAP:   vram_raddr = map_addr;
			tsr_pkg::ST_BG_LO:    vram_raddr = bg_rowaddr;
			tsr_pkg::ST_BG_HI:    vram_raddr = rowaddr_q + 13'd1;
			tsr_pkg::ST_BG_PIX:   line_we = (x_q[2:0] == 3'd7);
			tsr_pkg::ST_SP_START: vram_raddr = sp_addr;
			tsr_pkg::ST_SP_HI:    vram_raddr = rowaddr_q + 13'd1;
			tsr_pkg::ST_SP_RD:    line_raddr = w[4:0];
			tsr_pkg::ST_SP_WR: begin
				line_we    = 1'b1;
				line_waddr = w[4:0];
				line_wdata = sp_word;
			end
			tsr_pkg::ST_OUT_RD:   line_raddr = group_q;
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tsr_pkg::ST_CLEAR;
			clr_q    <= 13'd0;
			sel_q    <= 6'd0;
			x_q      <= 8'd0;
			spi_q    <= 4'd0;
			sword_q  <= 1'b0;
			group_q  <= 5'd0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tsr_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 13'd1;
			end
			if (start) begin
				sel_q   <= 6'd0;
				x_q     <= 8'd0;
				spi_q   <= 4'd0;
				sword_q <= 1'b0;
				group_q <= 5'd0;
			end
			if (state_q == tsr_pkg::ST_SEL) begin
				sel_q <= sel_q + 6'd1;
			end
			if (state_q == tsr_pkg::ST_BG_PIX) begin
				x_q <= x_q + 8'd1;
			end
			if ((state_q == tsr_pkg::ST_SP_START) && sp_go && skip) begin
				spi_q <= spi_q + 4'd1;
			end
			if (((state_q == tsr_pkg::ST_SP_RD) && !w_ok) || (state_q == tsr_pkg::ST_SP_WR)) begin
				sword_q <= !sword_q;
				if (sword_q) begin
					spi_q <= spi_q + 4'd1;
				end
			end
			if (state_q == tsr_pkg::ST_OUT_LD) begin
				ovalid_q <= 1'b1;
			end
			if ((state_q == tsr_pkg::ST_OUT_WAIT) && results.ready) begin
				ovalid_q <= 1'b0;
				group_q  <= group_q + 5'd1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			line_q <= items.line;
			win_q  <= win;
			off_q  <= !win && !cfg.ctrl[0];
			ym_q   <= win ? lw : items.line + cfg.scy;
			map_q  <= tsr_pkg::MAP_BASE +
			          ((win ? cfg.ctrl[6] : cfg.ctrl[3]) ? tsr_pkg::MAP_SIZE : 13'd0);
		end
		unique case (state_q)
			tsr_pkg::ST_BG_LO:    rowaddr_q <= bg_rowaddr;
			tsr_pkg::ST_BG_HI:    lo_q <= vram_rd;
			tsr_pkg::ST_BG_WT:    hi_q <= vram_rd;
			tsr_pkg::ST_BG_PIX:   pixacc_q[{x_q[2:0], 2'b00} +: 4] <= bg_entry;
			tsr_pkg::ST_SP_START: begin
				spr_q     <= cur;
				rowaddr_q <= sp_addr;
			end
			tsr_pkg::ST_SP_HI:    lo_q <= vram_rd;
			tsr_pkg::ST_SP_WT:    hi_q <= vram_rd;
			tsr_pkg::ST_OUT_LD: begin
				for (int k = 0; k < 8; k++) begin
					oshades_q[2*k +: 2] <= line_rd[4*k +: 2];
				end
				ogroup_q <= group_q;
				oline_q  <= line_q;
				olast_q  <= last_grp;
			end
			default: ;
		endcase
	end

	assign results.valid    = ovalid_q;
	assign results.shades   = oshades_q;
	assign results.group    = ogroup_q;
	assign results.line_out = oline_q;
	assign results.last     = olast_q;

	`TSR_ASSERT(a_valid_in_wait, !ovalid_q || (state_q == tsr_pkg::ST_OUT_WAIT), "result valid outside output wait")
	`TSR_ASSERT(a_no_accept_while_out, !(items.ready && ovalid_q), "input ready while a result is pending")
	`TSR_ASSERT_NEXT(a_render_starts, start, state_q == tsr_pkg::ST_SEL, "render item did not start selection")
	`TSR_ASSERT(a_last_group, !(ovalid_q && olast_q) || (ogroup_q == 5'(tsr_pkg::GROUPS - 1)), "last flag on wrong group")
endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench of the tile scanline renderer with a line predictor.
`default_nettype none
module testbench;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int SETTLE_CYCLES = 40;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [1:0]  func;
		logic [12:0] mem_addr;
		logic [7:0]  mem_data;
		logic [7:0]  line;
	} item_t;

	typedef struct {
		logic [15:0] shades;
		logic [4:0]  group;
		logic [7:0]  line_out;
		logic        last;
	} pixel_group_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	tsr_item_if items ();
	tsr_result_if results ();

	tile_scanline_renderer u_top (
		.clk(clk), .arst_n(arst_n), .items(items), .results(results),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	logic [7:0] vram_copy [tsr_pkg::VRAM_BYTES];
	logic [7:0] oam_copy [tsr_pkg::SPR_BYTES];
	logic [7:0] ctrl_reg, scx_reg, scy_reg, wtop_reg, bgp_reg, obp0_reg, obp1_reg;
	pixel_group_t pending_groups[$];
	int errors = 0;
	int quiet_cycles = 0;
	idle_mode_t idle_mode = IDLE_NONE;
	bit item_taken, group_taken;

	function automatic logic [1:0] tile_colour(input logic [12:0] row_addr, input int col);
		logic [7:0] lo, hi;
		int b;
		lo = vram_copy[row_addr];
		hi = vram_copy[13'(row_addr + 13'd1)];
		b = 7 - (col & 7);
		return {hi[b], lo[b]};
	endfunction

	function automatic void predict_line(input logic [7:0] ln);
		logic [31:0] picked [tsr_pkg::MAX_SPR];
		logic [31:0] t;
		logic [1:0] bg_idx [tsr_pkg::LINE_PIXELS];
		logic [1:0] pix [tsr_pkg::LINE_PIXELS];
		logic [1:0] c;
		logic [7:0] tile, flags, pal, ym, xm;
		logic [12:0] map;
		int height, cnt, j, sy, sx, row, base, x, p, lnum, k;
		bit win;
		pixel_group_t g;
		lnum = int'(ln);
		height = ctrl_reg[2] ? 16 : 8;
		cnt = 0;
		for (int i = 0; i < tsr_pkg::SPR_ENTRIES && cnt < tsr_pkg::MAX_SPR; i++) begin
			sy = int'(oam_copy[i*4]) - 16;
			if (lnum < sy || lnum >= sy + height)
				continue;
			j = cnt;
			cnt++;
			picked[j] = {oam_copy[i*4+3], oam_copy[i*4+2], oam_copy[i*4+1], oam_copy[i*4]};
			while (j > 0 && picked[j-1][15:8] < picked[j][15:8]) begin
				t = picked[j-1];
				picked[j-1] = picked[j];
				picked[j] = t;
				j--;
			end
		end
		win = ctrl_reg[5] && lnum >= int'(wtop_reg) && lnum - int'(wtop_reg) < 144;
		if (win) begin
			ym = 8'(lnum - int'(wtop_reg));
			map = ctrl_reg[6] ? tsr_pkg::MAP_BASE + tsr_pkg::MAP_SIZE : tsr_pkg::MAP_BASE;
		end else begin
			ym = 8'(lnum + int'(scy_reg));
			map = ctrl_reg[3] ? tsr_pkg::MAP_BASE + tsr_pkg::MAP_SIZE : tsr_pkg::MAP_BASE;
		end
		for (x = 0; x < tsr_pkg::LINE_PIXELS; x++) begin
			if (!win && !ctrl_reg[0]) begin
				bg_idx[x] = 2'd0;
			end else begin
				xm = win ? 8'(x) : 8'(x + int'(scx_reg));
				tile = vram_copy[13'(int'(map) + int'(ym[7:3]) * 32 + int'(xm[7:3]))];
				if (ctrl_reg[4])
					base = int'(tile) * 16;
				else if (tile < 8'd128)
					base = int'(tsr_pkg::SIGNED_BASE) + int'(tile) * 16;
				else
					base = int'(tsr_pkg::SIGNED_BASE) - (256 - int'(tile)) * 16;
				bg_idx[x] = tile_colour(13'(base + int'(ym[2:0]) * 2), int'(xm));
			end
			pix[x] = bgp_reg[bg_idx[x]*2 +: 2];
		end
		if (ctrl_reg[1]) begin
			for (int i = 0; i < cnt; i++) begin
				sy = int'(picked[i][7:0]) - 16;
				sx = int'(picked[i][15:8]) - 8;
				tile = picked[i][23:16];
				flags = picked[i][31:24];
				pal = flags[4] ? obp1_reg : obp0_reg;
				if (sx < -7)
					continue;
				if (height == 16)
					tile[0] = 1'b0;
				row = (lnum - sy) & 15;
				if (flags[6])
					row = height - 1 - row;
				base = int'(tile) * 16 + row * 2;
				for (int px = 0; px < 8; px++) begin
					p = sx + px;
					if (p < 0 || p >= tsr_pkg::LINE_PIXELS)
						continue;
					c = tile_colour(13'(base), flags[5] ? 7 - px : px);
					if (c == 2'd0)
						continue;
					if (flags[7] && bg_idx[p] != 2'd0)
						continue;
					pix[p] = pal[c*2 +: 2];
				end
			end
		end
		for (int gi = 0; gi < tsr_pkg::GROUPS; gi++) begin
			g.shades = '0;
			for (k = 0; k < 8; k++)
				g.shades[k*2 +: 2] = pix[gi*8 + k];
			g.group = 5'(gi);
			g.line_out = ln;
			g.last = (gi == tsr_pkg::GROUPS - 1);
			pending_groups.push_back(g);
		end
	endfunction

	function automatic void apply_item(input item_t it);
		case (it.func)
			tsr_pkg::FUNC_VRAM: vram_copy[it.mem_addr] = it.mem_data;
			tsr_pkg::FUNC_SPRITE:
				if (it.mem_addr < tsr_pkg::SPR_BYTES) oam_copy[it.mem_addr] = it.mem_data;
			tsr_pkg::FUNC_RENDER: predict_line(it.line);
			default: ;
		endcase
	endfunction

	task automatic send_item(input item_t it);
		bit acc;
		while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 74) ||
				(idle_mode == IDLE_BOTH && $urandom_range(99) < 15)) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid <= 1'b1;
		items.func <= it.func;
		items.mem_addr <= it.mem_addr;
		items.mem_data <= it.mem_data;
		items.line <= it.line;
		do begin
			@(negedge clk);
			acc = items.ready;
			@(posedge clk);
		end while (!acc);
		apply_item(it);
	endtask

	task automatic send(input logic [1:0] f, input int a, input int d, input int ln);
		item_t it;
		it.func = f;
		it.mem_addr = 13'(a);
		it.mem_data = 8'(d);
		it.line = 8'(ln);
		send_item(it);
	endtask

	task automatic drain;
		items.valid <= 1'b0;
		@(posedge clk);
		while (pending_groups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			tsr_pkg::REG_CTRL: ctrl_reg = value;
			tsr_pkg::REG_SCX:  scx_reg = value;
			tsr_pkg::REG_SCY:  scy_reg = value;
			tsr_pkg::REG_WTOP: wtop_reg = value;
			tsr_pkg::REG_BGP:  bgp_reg = value;
			tsr_pkg::REG_OBP0: obp0_reg = value;
			tsr_pkg::REG_OBP1: obp1_reg = value;
			default: ;
		endcase
	endtask

	task automatic write_all_regs(input logic [7:0] c, input logic [7:0] sx,
			input logic [7:0] sy, input logic [7:0] wt, input logic [7:0] bp,
			input logic [7:0] p0, input logic [7:0] p1);
		drain();
		write_reg(tsr_pkg::REG_CTRL, c);
		write_reg(tsr_pkg::REG_SCX, sx);
		write_reg(tsr_pkg::REG_SCY, sy);
		write_reg(tsr_pkg::REG_WTOP, wt);
		write_reg(tsr_pkg::REG_BGP, bp);
		write_reg(tsr_pkg::REG_OBP0, p0);
		write_reg(tsr_pkg::REG_OBP1, p1);
	endtask

	function automatic item_t random_item;
		item_t it;
		int r, ln;
		r = $urandom_range(99);
		it.mem_data = 8'($urandom);
		it.line = 8'($urandom_range(143));
		it.mem_addr = 13'($urandom);
		if (r < 30) begin
			it.func = tsr_pkg::FUNC_VRAM;
			it.mem_addr = 13'(int'(tsr_pkg::MAP_BASE) + $urandom_range(2047));
		end else if (r < 55) begin
			it.func = tsr_pkg::FUNC_VRAM;
			it.mem_addr = 13'($urandom_range(int'(tsr_pkg::MAP_BASE) - 1));
		end else if (r < 75) begin
			it.func = tsr_pkg::FUNC_SPRITE;
			it.mem_addr = 13'($urandom_range(tsr_pkg::SPR_BYTES - 1));
			if (it.mem_addr[1:0] == 2'd0) begin
				ln = $urandom_range(143);
				it.mem_data = 8'(ln + 16 - $urandom_range(15));
			end
		end else if (r < 80) begin
			it.func = tsr_pkg::FUNC_SPRITE;
		end else if (r < 82) begin
			it.func = FUNC_UNUSED;
			it.line = 8'($urandom);
		end else begin
			it.func = tsr_pkg::FUNC_RENDER;
			if ($urandom_range(9) == 0)
				it.line = 8'($urandom);
		end
		return it;
	endfunction

	task automatic test_reset_state;
		send(tsr_pkg::FUNC_RENDER, 0, 0, 0);
		send(tsr_pkg::FUNC_RENDER, 0, 0, 255);
	endtask

	task automatic test_background;
		send(tsr_pkg::FUNC_VRAM, 16'h0010, 8'hA5, 0);
		send(tsr_pkg::FUNC_VRAM, 16'h0011, 8'h3C, 0);
		send(tsr_pkg::FUNC_VRAM, 16'h0800, 8'hFF, 0);
		send(tsr_pkg::FUNC_VRAM, 16'h0801, 8'h0F, 0);
		send(tsr_pkg::FUNC_VRAM, 16'h1010, 8'h81, 0);
		send(tsr_pkg::FUNC_VRAM, int'(tsr_pkg::MAP_BASE), 8'h01, 0);
		send(tsr_pkg::FUNC_VRAM, int'(tsr_pkg::MAP_BASE) + 1, 8'h80, 0);
		send(tsr_pkg::FUNC_VRAM, int'(tsr_pkg::MAP_BASE + tsr_pkg::MAP_SIZE) + 2, 8'h01, 0);
		send(tsr_pkg::FUNC_VRAM, 8191, 8'hFF, 0);
		write_all_regs(8'h11, 8'd0, 8'd0, 8'd0, 8'h1B, 8'hE4, 8'hE4);
		send(tsr_pkg::FUNC_RENDER, 0, 0, 0);
		write_all_regs(8'h09, 8'd255, 8'd255, 8'd0, 8'hE4, 8'hE4, 8'hE4);
		send(tsr_pkg::FUNC_RENDER, 0, 0, 1);
		write_all_regs(8'h60, 8'd3, 8'd0, 8'd255, 8'h9C, 8'hE4, 8'hE4);
		send(tsr_pkg::FUNC_RENDER, 0, 0, 255);
		send(tsr_pkg::FUNC_RENDER, 0, 0, 143);
	endtask

	task automatic test_sprites;
		send(tsr_pkg::FUNC_SPRITE, 0, 16, 0);
		send(tsr_pkg::FUNC_SPRITE, 1, 0, 0);
		send(tsr_pkg::FUNC_SPRITE, 4, 16, 0);
		send(tsr_pkg::FUNC_SPRITE, 5, 163, 0);
		send(tsr_pkg::FUNC_SPRITE, 6, 1, 0);
		send(tsr_pkg::FUNC_SPRITE, 7, 8'hF0, 0);
		send(tsr_pkg::FUNC_SPRITE, 8, 10, 0);
		send(tsr_pkg::FUNC_SPRITE, 9, 12, 0);
		send(tsr_pkg::FUNC_SPRITE, 10, 1, 0);
		send(tsr_pkg::FUNC_SPRITE, 11, 8'h20, 0);
		send(tsr_pkg::FUNC_SPRITE, 8191, 8'h55, 0);
		send(FUNC_UNUSED, 0, 8'hFF, 0);
		write_all_regs(8'h17, 8'd0, 8'd0, 8'd0, 8'h1B, 8'h00, 8'hFF);
		send(tsr_pkg::FUNC_RENDER, 0, 0, 0);
		write_all_regs(8'h06, 8'd0, 8'd0, 8'd0, 8'h1B, 8'hE4, 8'h27);
		send(tsr_pkg::FUNC_RENDER, 0, 0, 7);
	endtask

	task automatic test_random_phase(input idle_mode_t mode, input int count, input bit pause);
		idle_mode = mode;
		for (int n = 0; n < count; n++) begin
			if (pause && n == count / 2)
				drain();
			send_item(random_item());
		end
	endtask

	task automatic test_random;
		idle_mode_t modes [4] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
		for (int ph = 0; ph < 6; ph++) begin
			idle_mode = IDLE_NONE;
			case (ph)
				0: write_all_regs(8'h13, 8'd0, 8'd0, 8'd0, 8'hE4, 8'hE4, 8'h1B);
				1: write_all_regs(8'hFF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
				2: write_all_regs(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
				default: write_all_regs(8'($urandom) | 8'h02, 8'($urandom), 8'($urandom),
						8'($urandom_range(160)), 8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			test_random_phase(modes[ph % 4], 70, ph == 1);
		end
	endtask

	always @(posedge clk)
		results.ready <= (idle_mode == IDLE_RECEIVER) ? ($urandom_range(99) >= 74) :
				(idle_mode == IDLE_BOTH) ? ($urandom_range(99) >= 15) : 1'b1;

	always @(negedge clk) begin
		pixel_group_t exp_g;
		item_taken = items.valid && items.ready;
		group_taken = results.valid && results.ready;
		if (group_taken) begin
			if (pending_groups.size() == 0) begin
				$error("unexpected transfer: group %0d line %0d", results.group, results.line_out);
				errors++;
			end else begin
				exp_g = pending_groups.pop_front();
				if (results.shades !== exp_g.shades) begin
					$error("shades: expected %h, actual %h", exp_g.shades, results.shades);
					errors++;
				end
				if (results.group !== exp_g.group) begin
					$error("group: expected %0d, actual %0d", exp_g.group, results.group);
					errors++;
				end
				if (results.line_out !== exp_g.line_out) begin
					$error("line_out: expected %0d, actual %0d", exp_g.line_out,
							results.line_out);
					errors++;
				end
				if (results.last !== exp_g.last) begin
					$error("last: expected %0d, actual %0d", exp_g.last, results.last);
					errors++;
				end
			end
		end
		if (item_taken || group_taken || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		items.valid <= 1'b0;
		items.func <= tsr_pkg::FUNC_VRAM;
		items.mem_addr <= '0;
		items.mem_data <= '0;
		items.line <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		foreach (vram_copy[i]) vram_copy[i] = 8'd0;
		foreach (oam_copy[i]) oam_copy[i] = 8'd0;
		ctrl_reg = 8'd0;
		scx_reg = 8'd0;
		scy_reg = 8'd0;
		wtop_reg = 8'd0;
		bgp_reg = 8'd27;
		obp0_reg = 8'd228;
		obp1_reg = 8'd228;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_background();
		test_sprites();
		test_random();
		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
